FILE: design/fbsc_pkg.sv
`default_nettype none

package fbsc_pkg;

    localparam int PLANE_COUNT  = 6;
    localparam int COORD_BITS   = 16;
    localparam int REG_COUNT    = 6;
    localparam int PLANE_BITS   = 64;
    localparam int FIELD_BITS   = 16;
    localparam int RADIUS_BITS  = 16;
    localparam int Q_SHIFT      = 14;
    localparam int CFG_IDX_BITS = 3;

    // planes above the register file are never tested
    localparam int CELL_COUNT = (PLANE_COUNT < REG_COUNT) ? PLANE_COUNT : REG_COUNT;

    // two register stages per cell plus the output register
    localparam int LATENCY = 2 * CELL_COUNT + 1;

    localparam int PROD_BITS = COORD_BITS + FIELD_BITS;
    localparam int SUM_BASE  = (PROD_BITS > FIELD_BITS + Q_SHIFT + 1) ?
                               PROD_BITS : FIELD_BITS + Q_SHIFT + 1;
    localparam int SUM_BITS  = SUM_BASE + 3;

    typedef enum logic {
        CMD_BOX    = 1'b0,
        CMD_SPHERE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                          valid;
        t_cmd                          cmd;
        logic signed [COORD_BITS-1:0]  lo_x;
        logic signed [COORD_BITS-1:0]  lo_y;
        logic signed [COORD_BITS-1:0]  lo_z;
        logic signed [COORD_BITS-1:0]  hi_x;
        logic signed [COORD_BITS-1:0]  hi_y;
        logic signed [COORD_BITS-1:0]  hi_z;
        logic        [RADIUS_BITS-1:0] radius;
        logic                          visible;
    } t_item;

endpackage

`default_nettype wire

FILE: design/fbsc_cell.sv
`default_nettype none

module fbsc_cell (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [fbsc_pkg::PLANE_BITS-1:0]   i_plane,
    input  wire fbsc_pkg::t_item                   i_item,
    output fbsc_pkg::t_item                        o_item
);
    import fbsc_pkg::*;

    logic signed [FIELD_BITS-1:0] w_nx, w_ny, w_nz, w_d;
    logic signed [PROD_BITS-1:0]  w_px_lo, w_px_hi, w_py_lo, w_py_hi, w_pz_lo, w_pz_hi;
    logic signed [PROD_BITS-1:0]  n_tx, n_ty, n_tz;
    logic signed [PROD_BITS-1:0]  r_tx, r_ty, r_tz;
    logic signed [SUM_BITS-1:0]   w_d_q, w_rad_q, w_sum;
    logic                         w_pass;
    t_item                        r_item1, r_item2;

    assign w_nx = i_plane[FIELD_BITS-1:0];
    assign w_ny = i_plane[2*FIELD_BITS-1:FIELD_BITS];
    assign w_nz = i_plane[3*FIELD_BITS-1:2*FIELD_BITS];
    assign w_d  = i_plane[4*FIELD_BITS-1:3*FIELD_BITS];

    // stage 1: per axis products, box keeps the larger term
    assign w_px_lo = PROD_BITS'(w_nx * i_item.lo_x);
    assign w_px_hi = PROD_BITS'(w_nx * i_item.hi_x);
    assign w_py_lo = PROD_BITS'(w_ny * i_item.lo_y);
    assign w_py_hi = PROD_BITS'(w_ny * i_item.hi_y);
    assign w_pz_lo = PROD_BITS'(w_nz * i_item.lo_z);
    assign w_pz_hi = PROD_BITS'(w_nz * i_item.hi_z);

    always_comb begin
        n_tx = w_px_lo;
        n_ty = w_py_lo;
        n_tz = w_pz_lo;
        if (i_item.cmd == CMD_BOX) begin
            if (w_px_hi > w_px_lo) n_tx = w_px_hi;
            if (w_py_hi > w_py_lo) n_ty = w_py_hi;
            if (w_pz_hi > w_pz_lo) n_tz = w_pz_hi;
        end
    end

    // stage 2: plane value plus radius bias must stay above zero
    assign w_d_q   = SUM_BITS'(w_d) <<< Q_SHIFT;
    assign w_rad_q = (r_item1.cmd == CMD_SPHERE) ?
                     (SUM_BITS'(r_item1.radius) << Q_SHIFT) : '0;
    assign w_sum   = SUM_BITS'(r_tx) + SUM_BITS'(r_ty) + SUM_BITS'(r_tz) + w_d_q + w_rad_q;
    assign w_pass  = (w_sum > 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item1.valid <= 1'b0;
            r_item2.valid <= 1'b0;
        end else begin
            r_item1.valid   <= i_item.valid;
            r_item2.valid   <= r_item1.valid;
            r_item1.cmd     <= i_item.cmd;
            r_item1.lo_x    <= i_item.lo_x;
            r_item1.lo_y    <= i_item.lo_y;
            r_item1.lo_z    <= i_item.lo_z;
            r_item1.hi_x    <= i_item.hi_x;
            r_item1.hi_y    <= i_item.hi_y;
            r_item1.hi_z    <= i_item.hi_z;
            r_item1.radius  <= i_item.radius;
            r_item1.visible <= i_item.visible;
            r_tx            <= n_tx;
            r_ty            <= n_ty;
            r_tz            <= n_tz;
            r_item2.cmd     <= r_item1.cmd;
            r_item2.lo_x    <= r_item1.lo_x;
            r_item2.lo_y    <= r_item1.lo_y;
            r_item2.lo_z    <= r_item1.lo_z;
            r_item2.hi_x    <= r_item1.hi_x;
            r_item2.hi_y    <= r_item1.hi_y;
            r_item2.hi_z    <= r_item1.hi_z;
            r_item2.radius  <= r_item1.radius;
            r_item2.visible <= r_item1.visible & w_pass;
        end
    end

    assign o_item = r_item2;

endmodule

`default_nettype wire

FILE: design/frustum_box_sphere_cull.sv
`default_nettype none

// Frustum cull of a box or sphere against up to six planes held in config registers.
// One item is taken on every cycle in which i_start is high (o_busy never rises) and
// its result comes out as a one-cycle o_valid strobe with o_visible after it has passed
// through every plane cell and the output register: each plane is a cell of two
// register stages, products first and then the plane sum, and the row hands items
// along from cell to cell. Results cannot be held off by the receiver. Plane
// registers are written through the cfg channel, which is always ready; write them
// only while no item is in flight.

module frustum_box_sphere_cull (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    output logic                                        o_busy,
    input  wire logic                                   i_cmd,
    input  wire logic signed [fbsc_pkg::COORD_BITS-1:0] i_lo_x,
    input  wire logic signed [fbsc_pkg::COORD_BITS-1:0] i_lo_y,
    input  wire logic signed [fbsc_pkg::COORD_BITS-1:0] i_lo_z,
    input  wire logic signed [fbsc_pkg::COORD_BITS-1:0] i_hi_x,
    input  wire logic signed [fbsc_pkg::COORD_BITS-1:0] i_hi_y,
    input  wire logic signed [fbsc_pkg::COORD_BITS-1:0] i_hi_z,
    input  wire logic [fbsc_pkg::RADIUS_BITS-1:0]       i_sphere_radius,
    output logic                                        o_valid,
    output logic                                        o_visible,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [fbsc_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire logic [fbsc_pkg::PLANE_BITS-1:0]        i_cfg_data
);
    import fbsc_pkg::*;

    logic [PLANE_BITS-1:0] r_plane [REG_COUNT];
    t_item                 w_item  [CELL_COUNT+1];
    logic                  r_valid, r_visible;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) r_plane[i] <= '0;
        end else if (i_cfg_valid && o_cfg_ready && i_cfg_index < CFG_IDX_BITS'(REG_COUNT)) begin
            r_plane[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        w_item[0].valid   = i_start & ~o_busy;
        w_item[0].cmd     = t_cmd'(i_cmd);
        w_item[0].lo_x    = i_lo_x;
        w_item[0].lo_y    = i_lo_y;
        w_item[0].lo_z    = i_lo_z;
        w_item[0].hi_x    = i_hi_x;
        w_item[0].hi_y    = i_hi_y;
        w_item[0].hi_z    = i_hi_z;
        w_item[0].radius  = i_sphere_radius;
        w_item[0].visible = 1'b1;
    end

    for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
        fbsc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_plane (r_plane[g]),
            .i_item  (w_item[g]),
            .o_item  (w_item[g+1])
        );
    end

    // visible is forced low between strobes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_visible <= 1'b0;
        end else begin
            r_valid   <= w_item[CELL_COUNT].valid;
            r_visible <= w_item[CELL_COUNT].valid & w_item[CELL_COUNT].visible;
        end
    end

    assign o_valid   = r_valid;
    assign o_visible = r_visible;

endmodule

`default_nettype wire

FILE: design/fbsc_checker.sv
`default_nettype none

module fbsc_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic o_busy,
    input  wire logic o_valid,
    input  wire logic o_visible,
    input  wire logic o_cfg_ready
);
    import fbsc_pkg::*;

    logic w_accept;
    assign w_accept = i_start & ~o_busy;

    // every accepted item yields a result after the fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_valid)
        else $error("accepted item gave no result");

    // no result without an accepted item
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LATENCY))
        else $error("result without transfer");

    a_visible_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_visible)
        else $error("visible outside a result");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !o_busy && o_cfg_ready)
        else $error("block stalled a transfer");

endmodule

bind frustum_box_sphere_cull fbsc_checker u_fbsc_checker (.*);

`default_nettype wire

FILE: sim/frustum_box_sphere_cull_tb.sv
`timescale 1ns / 1ps

module frustum_box_sphere_cull_tb;
    import fbsc_pkg::*;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_RIGHT  = 3'd0,
        REG_LEFT   = 3'd1,
        REG_BOTTOM = 3'd2,
        REG_TOP    = 3'd3,
        REG_BACK   = 3'd4,
        REG_FRONT  = 3'd5,
        REG_SPARE6 = 3'd6,
        REG_SPARE7 = 3'd7
    } t_reg_idx;

    typedef struct {
        bit visible;
        int serial;
    } t_vis_pending;

    localparam int Q_ONE    = 1 << Q_SHIFT;
    localparam int RAND_ITEMS_PER_PHASE = 158;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_start = 1'b0;
    logic                          i_cmd = 1'b0;
    logic signed [COORD_BITS-1:0]  i_lo_x = '0;
    logic signed [COORD_BITS-1:0]  i_lo_y = '0;
    logic signed [COORD_BITS-1:0]  i_lo_z = '0;
    logic signed [COORD_BITS-1:0]  i_hi_x = '0;
    logic signed [COORD_BITS-1:0]  i_hi_y = '0;
    logic signed [COORD_BITS-1:0]  i_hi_z = '0;
    logic [RADIUS_BITS-1:0]        i_sphere_radius = '0;
    logic                          i_cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0]       i_cfg_index = '0;
    logic [PLANE_BITS-1:0]         i_cfg_data = '0;
    logic                          o_busy;
    logic                          o_valid;
    logic                          o_visible;
    logic                          o_cfg_ready;

    logic [PLANE_BITS-1:0] plane_regs [REG_COUNT];
    t_vis_pending          pending_vis_q [$];
    t_vis_pending          oldest_vis;

    int n_errors   = 0;
    int n_sent     = 0;
    int n_box      = 0;
    int n_sphere   = 0;
    int n_visible  = 0;
    int n_culled   = 0;
    int n_settings = 0;

    frustum_box_sphere_cull u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_cmd           (i_cmd),
        .i_lo_x          (i_lo_x),
        .i_lo_y          (i_lo_y),
        .i_lo_z          (i_lo_z),
        .i_hi_x          (i_hi_x),
        .i_hi_y          (i_hi_y),
        .i_hi_z          (i_hi_z),
        .i_sphere_radius (i_sphere_radius),
        .o_valid         (o_valid),
        .o_visible       (o_visible),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic longint larger_term(longint n, longint a, longint b);
        longint ta;
        longint tb;
        ta = n * a;
        tb = n * b;
        return (ta > tb) ? ta : tb;
    endfunction

    function automatic bit predict_visible(
        input t_cmd                         cmd,
        input logic signed [COORD_BITS-1:0] lx, ly, lz, hx, hy, hz,
        input logic [RADIUS_BITS-1:0]       rad
    );
        longint nx;
        longint ny;
        longint nz;
        longint dq;
        longint v;
        bit     vis;
        vis = 1'b1;
        for (int i = 0; i < REG_COUNT && i < PLANE_COUNT; i++) begin
            nx = longint'($signed(plane_regs[i][15:0]));
            ny = longint'($signed(plane_regs[i][31:16]));
            nz = longint'($signed(plane_regs[i][47:32]));
            dq = longint'($signed(plane_regs[i][63:48])) * Q_ONE;
            if (cmd == CMD_BOX) begin
                v = larger_term(nx, longint'(lx), longint'(hx))
                  + larger_term(ny, longint'(ly), longint'(hy))
                  + larger_term(nz, longint'(lz), longint'(hz)) + dq;
                if (!(v > 0))
                    vis = 1'b0;
            end else begin
                v = nx * longint'(lx) + ny * longint'(ly) + nz * longint'(lz) + dq;
                if (v <= -(longint'(rad) * Q_ONE))
                    vis = 1'b0;
            end
        end
        return vis;
    endfunction

    // ---------------------------------------------------------------- helpers

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic logic [PLANE_BITS-1:0] pack_plane(int nx, int ny, int nz, int d);
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] fz;
        logic [15:0] fd;
        fx = nx[15:0];
        fy = ny[15:0];
        fz = nz[15:0];
        fd = d[15:0];
        return {fd, fz, fy, fx};
    endfunction

    // axis-aligned box frustum, plane r keeps points with |coord| below ext on its side
    function automatic logic [PLANE_BITS-1:0] cube_plane(int r, int ext);
        int s;
        s = (r == REG_LEFT || r == REG_BOTTOM || r == REG_BACK) ? Q_ONE : -Q_ONE;
        case (r / 2)
            0:       return pack_plane(s, 0, 0, ext);
            1:       return pack_plane(0, s, 0, ext);
            default: return pack_plane(0, 0, s, ext);
        endcase
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord(int span);
        logic [31:0] w;
        int          v;
        if (span <= 0) begin
            w = $urandom();
            return w[COORD_BITS-1:0];
        end
        v = int'($urandom_range(2 * span)) - span;
        return v[COORD_BITS-1:0];
    endfunction

    task automatic write_plane(input t_reg_idx idx, input logic [PLANE_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx < REG_COUNT)
            plane_regs[idx] = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_same_planes(input logic [PLANE_BITS-1:0] data);
        for (int r = 0; r < REG_COUNT; r++)
            write_plane(t_reg_idx'(r), data);
        n_settings++;
    endtask

    task automatic load_cube_planes(input int ext);
        for (int r = 0; r < REG_COUNT; r++)
            write_plane(t_reg_idx'(r), cube_plane(r, ext));
        n_settings++;
    endtask

    // stop sending and let everything in flight come out
    task automatic wait_drain();
        i_start <= 1'b0;
        while (pending_vis_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic send_item(
        input t_cmd                         cmd,
        input logic signed [COORD_BITS-1:0] lx, ly, lz, hx, hy, hz,
        input logic [RADIUS_BITS-1:0]       rad
    );
        t_vis_pending p;
        i_start         <= 1'b1;
        i_cmd           <= cmd;
        i_lo_x          <= lx;
        i_lo_y          <= ly;
        i_lo_z          <= lz;
        i_hi_x          <= hx;
        i_hi_y          <= hy;
        i_hi_z          <= hz;
        i_sphere_radius <= rad;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        p.visible = predict_visible(cmd, lx, ly, lz, hx, hy, hz, rad);
        p.serial  = n_sent;
        pending_vis_q.push_back(p);
        n_sent++;
        if (cmd == CMD_BOX)
            n_box++;
        else
            n_sphere++;
        if (p.visible)
            n_visible++;
        else
            n_culled++;
    endtask

    task automatic sender_gap(input int pct);
        if (int'($urandom_range(99)) < pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // ---------------------------------------------------------------- result check

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_vis_q.size() == 0) begin
                report_mismatch($sformatf("result visible=%0b with nothing pending",
                                          o_visible));
            end else begin
                oldest_vis = pending_vis_q.pop_front();
                if (o_visible !== oldest_vis.visible)
                    report_mismatch($sformatf("item %0d visible expected %0b got %b",
                                              oldest_vis.serial, oldest_vis.visible,
                                              o_visible));
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // all planes still zero: every box culled, spheres culled only at radius zero
    task automatic test_unwritten_planes();
        send_item(CMD_BOX, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd10, 16'd0);
        send_item(CMD_SPHERE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
        send_item(CMD_SPHERE, 16'sd5, -16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd1);
        send_item(CMD_SPHERE, 16'sh7fff, 16'sh8000, 16'sh7fff,
                  16'sh8000, 16'sh7fff, 16'sh8000, 16'hffff);
        wait_drain();
    endtask

    task automatic test_cube_frustum();
        load_cube_planes(1000);
        send_item(CMD_BOX, -16'sd10, -16'sd10, -16'sd10, 16'sd10, 16'sd10, 16'sd10, 16'd0);
        send_item(CMD_BOX, 16'sd2000, 16'sd0, 16'sd0, 16'sd3000, 16'sd10, 16'sd10, 16'd0);
        send_item(CMD_BOX, 16'sd900, 16'sd0, 16'sd0, 16'sd1100, 16'sd10, 16'sd10, 16'd0);
        // face exactly on the plane gives value zero, which culls
        send_item(CMD_BOX, 16'sd1000, 16'sd0, 16'sd0, 16'sd2000, 16'sd10, 16'sd10, 16'd0);
        // inverted box, corners still taken as given
        send_item(CMD_BOX, 16'sd1100, 16'sd0, 16'sd0, -16'sd1100, 16'sd10, 16'sd10, 16'd0);
        send_item(CMD_BOX, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff);
        // sphere just touching from outside, then one unit larger
        send_item(CMD_SPHERE, 16'sd1500, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd500);
        send_item(CMD_SPHERE, 16'sd1500, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd501);
        send_item(CMD_SPHERE, 16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'd0);
        send_item(CMD_SPHERE, 16'sh8000, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 16'sd0,
                  16'hffff);
        send_item(CMD_SPHERE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'd0);
        wait_drain();
    endtask

    // writes to indexes past the plane file must leave the planes alone
    task automatic test_spare_index();
        write_plane(REG_SPARE6, {$urandom(), $urandom()});
        write_plane(REG_SPARE7, '0);
        send_item(CMD_BOX, -16'sd10, -16'sd10, -16'sd10, 16'sd10, 16'sd10, 16'sd10, 16'd0);
        send_item(CMD_SPHERE, 16'sd1500, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd400);
        wait_drain();
    endtask

    task automatic test_extreme_planes();
        load_same_planes(64'h8000_8000_8000_8000);
        send_item(CMD_BOX, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh8000, 16'sh8000, 16'sh8000, 16'd0);
        send_item(CMD_SPHERE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0,
                  16'hffff);
        wait_drain();
        load_same_planes(64'h7fff_7fff_7fff_7fff);
        send_item(CMD_BOX, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh8000, 16'sh8000, 16'sh8000, 16'd0);
        send_item(CMD_SPHERE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0,
                  16'hffff);
        wait_drain();
        load_same_planes(64'hffff_ffff_ffff_ffff);
        send_item(CMD_BOX, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
        send_item(CMD_SPHERE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd1);
        send_item(CMD_SPHERE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd2);
        wait_drain();
    endtask

    task automatic load_random_planes();
        int style;
        int ext;
        style = $urandom_range(7);
        for (int r = 0; r < REG_COUNT; r++) begin
            ext = $urandom_range(300, 3000);
            if (style == 0)
                write_plane(t_reg_idx'(r), {$urandom(), $urandom()});
            else if (style <= 3)
                write_plane(t_reg_idx'(r), cube_plane(r, ext));
            else
                write_plane(t_reg_idx'(r),
                            pack_plane(int'($urandom_range(32768)) - Q_ONE,
                                       int'($urandom_range(32768)) - Q_ONE,
                                       int'($urandom_range(32768)) - Q_ONE,
                                       int'($urandom_range(3000)) - 500));
        end
        if ($urandom_range(3) == 0)
            write_plane($urandom_range(1) ? REG_SPARE7 : REG_SPARE6,
                        {$urandom(), $urandom()});
        n_settings++;
    endtask

    task automatic send_random_item();
        logic [31:0]                  w;
        t_cmd                         cmd;
        int                           span;
        int                           half;
        logic signed [COORD_BITS-1:0] cx, cy, cz;
        logic [RADIUS_BITS-1:0]       rad;
        w    = $urandom();
        cmd  = w[0] ? CMD_SPHERE : CMD_BOX;
        span = w[1] ? 1500 : 3500;
        rad  = (w[7:4] == 4'd0) ? w[31:16] : RADIUS_BITS'($urandom_range(1500));
        if (w[11:8] < 4'd3) begin
            // noise: any field value, inverted boxes included
            send_item(cmd, rand_coord(0), rand_coord(0), rand_coord(0),
                      rand_coord(0), rand_coord(0), rand_coord(0), w[31:16]);
        end else if (cmd == CMD_SPHERE) begin
            send_item(cmd, rand_coord(span), rand_coord(span), rand_coord(span),
                      rand_coord(0), rand_coord(0), rand_coord(0), rad);
        end else begin
            cx   = rand_coord(span);
            cy   = rand_coord(span);
            cz   = rand_coord(span);
            half = $urandom_range(span / 3);
            send_item(cmd, COORD_BITS'(cx - half), COORD_BITS'(cy - half),
                      COORD_BITS'(cz - half), COORD_BITS'(cx + half),
                      COORD_BITS'(cy + half), COORD_BITS'(cz + half), w[31:16]);
        end
    endtask

    task automatic test_random_traffic();
        int idle_pct [3] = '{0, 50, 9};
        for (int ph = 0; ph < 6; ph++) begin
            wait_drain();
            load_random_planes();
            for (int k = 0; k < RAND_ITEMS_PER_PHASE; k++) begin
                send_random_item();
                if (k == RAND_ITEMS_PER_PHASE / 2)
                    wait_drain();
                else
                    sender_gap(idle_pct[ph % 3]);
            end
        end
        wait_drain();
    endtask

    // ---------------------------------------------------------------- run

    initial begin
        int waited;
        for (int r = 0; r < REG_COUNT; r++)
            plane_regs[r] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unwritten_planes();
        test_cube_frustum();
        test_spare_index();
        test_extreme_planes();
        test_random_traffic();

        i_start <= 1'b0;
        waited = 0;
        while (pending_vis_q.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 2) @(posedge i_clk);
        if (pending_vis_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_vis_q.size()));

        $display("ran %0d items (%0d boxes, %0d spheres) over %0d plane settings",
                 n_sent, n_box, n_sphere, n_settings);
        $display("predicted %0d visible and %0d culled, %0d mismatches",
                 n_visible, n_culled, n_errors);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_vis_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
